// ===== sv/sensor_advert_tlv_parser_top_defines.svh =====
// Assertion macros shared by the sensor advertisement parser RTL.
`ifndef SENSOR_ADVERT_TLV_PARSER_TOP_DEFINES_SVH
`define SENSOR_ADVERT_TLV_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SAT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication with a delayed consequent, checked outside reset.
`define SAT_ASSERT_TWO(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

// ===== sv/sat_pkg.sv =====
// Types and constants shared by the sensor advertisement parser modules.
`timescale 1ns / 1ps
`default_nettype none

package sat_pkg;

    // Configuration register indexes and reset values
    localparam int CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CFG_COMPANY_ID   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_CLIMATE_TYPE = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_BATTERY_TYPE = 2'd2;
    localparam logic [15:0] CompanyIdReset   = 16'h0157;
    localparam logic [7:0]  ClimateTypeReset = 8'h0D;
    localparam logic [7:0]  BatteryTypeReset = 8'h0A;

    // Record rules
    localparam logic [7:0] ClimateMinLen = 8'd4;
    localparam logic [7:0] BatteryMinLen = 8'd1;
    localparam logic [7:0] StageDepth    = 8'd3;
    localparam logic [1:0] HeaderLen     = 2'd2;

    // Operation queue between front and back
    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_LENGTH,
        PH_VALUE
    } t_phase;

    typedef enum logic [1:0] {
        CM_NONE,
        CM_CLIMATE,
        CM_BATTERY
    } t_commit;

    typedef struct packed {
        logic [15:0] company_id;
        logic [7:0]  climate_type;
        logic [7:0]  battery_type;
    } t_cfg;

    // One classified byte, as handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       stage_en;
        logic [1:0] stage_idx;
        t_commit    commit;
        logic       last;
        logic       good;
    } t_op;

    typedef struct packed {
        logic               accepted;
        logic               climate_valid;
        logic signed [15:0] temperature_tenths;
        logic [7:0]         humidity_percent;
        logic               battery_valid;
        logic [7:0]         battery_percent;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

// ===== sv/sat_front.sv =====
// Front part: header check and record walk; classifies each byte into an operation.
`timescale 1ns / 1ps
`default_nettype none

module sat_front import sat_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    output t_op             o_op
);

    logic [1:0] r_hdr_pos, n_hdr_pos;
    logic       r_hdr_match, n_hdr_match;
    t_phase     r_phase, n_phase;
    logic [7:0] r_rtype, n_rtype;
    logic [7:0] r_rlen, n_rlen;
    logic [7:0] r_vcount, n_vcount;

    logic [7:0] w_want;
    logic [7:0] w_vc_inc;
    t_commit    w_kind;

    // Pick the commit kind of the current record
    always_comb begin
        w_kind = CM_NONE;
        if (r_rtype == i_cfg.climate_type) begin
            if (r_rlen >= ClimateMinLen) begin
                w_kind = CM_CLIMATE;
            end
        end else if (r_rtype == i_cfg.battery_type) begin
            if (r_rlen >= BatteryMinLen) begin
                w_kind = CM_BATTERY;
            end
        end
    end

    assign w_want   = (r_hdr_pos == 2'd0) ? i_cfg.company_id[7:0] : i_cfg.company_id[15:8];
    assign w_vc_inc = r_vcount + 8'd1;

    // Advance the parse state and classify the byte
    always_comb begin
        n_hdr_pos   = r_hdr_pos;
        n_hdr_match = r_hdr_match;
        n_phase     = r_phase;
        n_rtype     = r_rtype;
        n_rlen      = r_rlen;
        n_vcount    = r_vcount;

        o_op.data      = i_data_byte;
        o_op.stage_en  = 1'b0;
        o_op.stage_idx = r_vcount[1:0];
        o_op.commit    = CM_NONE;
        o_op.last      = i_last_byte;

        if (r_hdr_pos < HeaderLen) begin
            if (i_data_byte != w_want) begin
                n_hdr_match = 1'b0;
            end
            n_hdr_pos = r_hdr_pos + 2'd1;
        end else begin
            case (r_phase)
                PH_TYPE: begin
                    n_rtype = i_data_byte;
                    n_phase = PH_LENGTH;
                end
                PH_LENGTH: begin
                    n_rlen   = i_data_byte;
                    n_vcount = 8'd0;
                    n_phase  = (i_data_byte == 8'd0) ? PH_TYPE : PH_VALUE;
                end
                PH_VALUE: begin
                    o_op.stage_en = (r_vcount < StageDepth);
                    if (w_vc_inc >= r_rlen) begin
                        o_op.commit = w_kind;
                        n_phase     = PH_TYPE;
                        n_vcount    = 8'd0;
                    end else begin
                        n_vcount = w_vc_inc;
                    end
                end
                default: begin
                    n_phase = PH_TYPE;
                end
            endcase
        end

        o_op.good = (n_hdr_pos >= HeaderLen) && n_hdr_match;

        // Drop all packet state after the final byte
        if (i_last_byte) begin
            n_hdr_pos   = 2'd0;
            n_hdr_match = 1'b1;
            n_phase     = PH_TYPE;
            n_rtype     = 8'd0;
            n_rlen      = 8'd0;
            n_vcount    = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pos   <= 2'd0;
            r_hdr_match <= 1'b1;
            r_phase     <= PH_TYPE;
            r_rtype     <= 8'd0;
            r_rlen      <= 8'd0;
            r_vcount    <= 8'd0;
        end else if (i_accept) begin
            r_hdr_pos   <= n_hdr_pos;
            r_hdr_match <= n_hdr_match;
            r_phase     <= n_phase;
            r_rtype     <= n_rtype;
            r_rlen      <= n_rlen;
            r_vcount    <= n_vcount;
        end
    end

endmodule

`default_nettype wire

// ===== sv/sat_queue.sv =====
// Short operation queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module sat_queue import sat_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_op  i_op,
    input  wire logic i_pop,
    output t_op       o_op,
    output t_q_status o_status
);

    t_op              r_mem [QDepth];
    logic [QPtrW-1:0] r_wr_ptr;
    logic [QPtrW-1:0] r_rd_ptr;
    logic [QCntW-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_status.full  = (r_count == QCntW'(QDepth));
    assign o_status.empty = (r_count == '0);
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_op   = r_mem[r_rd_ptr];

    // Store the pushed item
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QPtrW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPtrW'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + QCntW'(1);
                2'b01:   r_count <= r_count - QCntW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/sat_back.sv =====
// Back part: stages value bytes, commits records and builds the packet result.
`timescale 1ns / 1ps
`default_nettype none

module sat_back import sat_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_op  i_op,
    input  wire logic i_op_valid,
    output logic      o_op_take,
    input  wire logic i_res_pop,
    output logic      o_res_valid,
    output t_result   o_res
);

    logic [7:0]  r_stage [3];
    logic [7:0]  n_stage [3];
    logic [15:0] r_temp, n_temp;
    logic [7:0]  r_hum, n_hum;
    logic [7:0]  r_bat, n_bat;
    logic        r_found_cl, n_found_cl;
    logic        r_found_bt, n_found_bt;
    logic        r_res_valid;
    t_result     r_res, n_res;
    logic        w_cl;
    logic        w_bt;

    // Take an item unless it is a final byte and the result slot stays full
    assign o_op_take   = i_op_valid && (!i_op.last || !r_res_valid || i_res_pop);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // Apply the stage write, then the commit that may use it
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_stage[k] = r_stage[k];
        end
        if (i_op.stage_en) begin
            n_stage[i_op.stage_idx] = i_op.data;
        end

        n_temp     = r_temp;
        n_hum      = r_hum;
        n_bat      = r_bat;
        n_found_cl = r_found_cl;
        n_found_bt = r_found_bt;
        case (i_op.commit)
            CM_CLIMATE: begin
                n_temp     = {n_stage[1], n_stage[0]};
                n_hum      = n_stage[2];
                n_found_cl = 1'b1;
            end
            CM_BATTERY: begin
                n_bat      = n_stage[0];
                n_found_bt = 1'b1;
            end
            default: begin
            end
        endcase

        // Build the result from the updated packet state
        w_cl = i_op.good && n_found_cl;
        w_bt = i_op.good && n_found_bt;
        n_res.accepted           = w_cl || w_bt;
        n_res.climate_valid      = w_cl;
        n_res.temperature_tenths = w_cl ? n_temp : 16'sd0;
        n_res.humidity_percent   = w_cl ? n_hum : 8'd0;
        n_res.battery_valid      = w_bt;
        n_res.battery_percent    = w_bt ? n_bat : 8'd0;
    end

    // Hold staged and committed values
    always_ff @(posedge i_clk) begin
        if (o_op_take) begin
            for (int k = 0; k < 3; k++) begin
                r_stage[k] <= n_stage[k];
            end
            r_temp <= n_temp;
            r_hum  <= n_hum;
            r_bat  <= n_bat;
        end
        if (o_op_take && i_op.last) begin
            r_res <= n_res;
        end
    end

    // Track found flags and the result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found_cl  <= 1'b0;
            r_found_bt  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (o_op_take) begin
                r_found_cl <= i_op.last ? 1'b0 : n_found_cl;
                r_found_bt <= i_op.last ? 1'b0 : n_found_bt;
            end
            if (o_op_take && i_op.last) begin
                r_res_valid <= 1'b1;
            end else if (i_res_pop) begin
                r_res_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/sensor_advert_tlv_parser_top.sv =====
// Throughput: one byte per cycle while the queue is not full; a four-entry operation
// queue parts front and back. A packet's final byte is written into the queue behind
// any items it holds; once the back takes it, the result register loads the result,
// which shows on the result ports until pop takes it. The single result register
// stalls the back only on a final byte while full.
// Reset: synchronous, active low; clears parse state, queue and result slot and
// loads the configuration registers with their reset values.
`timescale 1ns / 1ps
`default_nettype none
`include "sensor_advert_tlv_parser_top_defines.svh"

module sensor_advert_tlv_parser_top import sat_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CfgIdxW-1:0]  i_cfg_idx,
    input  wire logic [15:0]         i_cfg_wdata,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [7:0]          i_data_byte,
    input  wire logic                i_last_byte,
    output logic                     empty,
    input  wire logic                pop,
    output logic                     o_accepted,
    output logic                     o_climate_valid,
    output logic signed [15:0]       o_temperature_tenths,
    output logic [7:0]               o_humidity_percent,
    output logic                     o_battery_valid,
    output logic [7:0]               o_battery_percent
);

    t_cfg      r_cfg;
    t_op       w_front_op;
    t_op       w_head_op;
    t_q_status w_q_status;
    logic      w_accept;
    logic      w_take;
    logic      w_res_valid;
    t_result   w_res;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.company_id   <= CompanyIdReset;
            r_cfg.climate_type <= ClimateTypeReset;
            r_cfg.battery_type <= BatteryTypeReset;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COMPANY_ID:   r_cfg.company_id   <= i_cfg_wdata;
                CFG_CLIMATE_TYPE: r_cfg.climate_type <= i_cfg_wdata[7:0];
                CFG_BATTERY_TYPE: r_cfg.battery_type <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    assign full     = w_q_status.full;
    assign w_accept = push && !w_q_status.full;

    sat_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (w_accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_op        (w_front_op)
    );

    sat_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_accept),
        .i_op     (w_front_op),
        .i_pop    (w_take),
        .o_op     (w_head_op),
        .o_status (w_q_status)
    );

    sat_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_head_op),
        .i_op_valid  (!w_q_status.empty),
        .o_op_take   (w_take),
        .i_res_pop   (pop),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    assign empty                = !w_res_valid;
    assign o_accepted           = w_res.accepted;
    assign o_climate_valid      = w_res.climate_valid;
    assign o_temperature_tenths = w_res.temperature_tenths;
    assign o_humidity_percent   = w_res.humidity_percent;
    assign o_battery_valid      = w_res.battery_valid;
    assign o_battery_percent    = w_res.battery_percent;

    `SAT_ASSERT_NOW(a_accept_flags, !empty,
        o_accepted == (o_climate_valid || o_battery_valid), "accept flag disagrees with valids")
    `SAT_ASSERT_NOW(a_climate_zero, !empty && !o_climate_valid,
        o_temperature_tenths == 16'sd0 && o_humidity_percent == 8'd0,
        "climate fields set without a climate record")
    `SAT_ASSERT_TWO(a_result_latency, w_accept && i_last_byte && w_q_status.empty && empty,
        !empty, "result missing two cycles after final byte")

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the sensor advertisement record parser.
`timescale 1ns / 1ps

import sat_pkg::*;

module tb_top;

    // Reset values of the registers and parser sizes, as the block is specified
    localparam logic [15:0] CompanyIdDefault   = 16'd343;
    localparam logic [7:0]  ClimateCodeDefault = 8'h0D;
    localparam logic [7:0]  BatteryCodeDefault = 8'h0A;
    localparam int          ClimateLenMin      = 4;
    localparam int          BatteryLenMin      = 1;
    localparam int          StagedMax          = 3;
    localparam int          HeaderBytes        = 2;
    localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;

    localparam int BytesPerSetting = 310;
    localparam int SettleCycles    = 12;
    localparam int HoldOffCycles   = 300;
    localparam int WatchdogLimit   = 2000;
    localparam int ReportMax       = 10;

    // Predicts the report of each packet and checks the block's reports in order
    class advert_scoreboard;
        logic [15:0] company_id;
        logic [7:0]  climate_code;
        logic [7:0]  battery_code;
        int          hdr_pos;
        logic        hdr_ok;
        t_phase      phase;
        logic [7:0]  rec_type;
        logic [7:0]  rec_len;
        int          val_cnt;
        logic [7:0]  staged [StagedMax];
        logic [15:0] temp_raw;
        logic [7:0]  humidity;
        logic [7:0]  battery;
        logic        got_climate;
        logic        got_battery;
        t_result     expected_reports [$];
        int          errors;
        int          bytes_seen;
        int          reports_seen;
        int          accepted_seen;
        int          climate_seen;
        int          battery_seen;

        function new();
            company_id   = CompanyIdDefault;
            climate_code = ClimateCodeDefault;
            battery_code = BatteryCodeDefault;
            start_packet();
        endfunction

        function void start_packet();
            hdr_pos     = 0;
            hdr_ok      = 1'b1;
            phase       = PH_TYPE;
            rec_type    = '0;
            rec_len     = '0;
            val_cnt     = 0;
            foreach (staged[i]) staged[i] = '0;
            temp_raw    = '0;
            humidity    = '0;
            battery     = '0;
            got_climate = 1'b0;
            got_battery = 1'b0;
        endfunction

        function void write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
            case (idx)
                CFG_COMPANY_ID:   company_id   = val;
                CFG_CLIMATE_TYPE: climate_code = val[7:0];
                CFG_BATTERY_TYPE: battery_code = val[7:0];
                default: ;
            endcase
        endfunction

        // Take the values of a finished record; climate wins when both codes match
        function void commit_record();
            if (rec_type == climate_code) begin
                if (rec_len >= ClimateLenMin) begin
                    temp_raw    = {staged[1], staged[0]};
                    humidity    = staged[2];
                    got_climate = 1'b1;
                end
            end else if (rec_type == battery_code) begin
                if (rec_len >= BatteryLenMin) begin
                    battery     = staged[0];
                    got_battery = 1'b1;
                end
            end
        endfunction

        function void note_byte(input logic [7:0] b, input logic lst);
            t_result want;
            logic    good;
            bytes_seen++;
            // Walk header, then type, length and value bytes
            if (hdr_pos < HeaderBytes) begin
                if (b != ((hdr_pos == 0) ? company_id[7:0] : company_id[15:8]))
                    hdr_ok = 1'b0;
                hdr_pos++;
            end else begin
                case (phase)
                    PH_TYPE: begin
                        rec_type = b;
                        phase    = PH_LENGTH;
                    end
                    PH_LENGTH: begin
                        rec_len = b;
                        val_cnt = 0;
                        foreach (staged[i]) staged[i] = '0;
                        phase   = (b == 8'd0) ? PH_TYPE : PH_VALUE;
                    end
                    default: begin
                        if (val_cnt < StagedMax)
                            staged[val_cnt] = b;
                        val_cnt++;
                        if (val_cnt >= rec_len) begin
                            commit_record();
                            phase   = PH_TYPE;
                            val_cnt = 0;
                        end
                    end
                endcase
            end
            if (!lst)
                return;
            // Build the report of the finished packet
            good                    = (hdr_pos >= HeaderBytes) && hdr_ok;
            want.climate_valid      = good && got_climate;
            want.battery_valid      = good && got_battery;
            want.accepted           = want.climate_valid || want.battery_valid;
            want.temperature_tenths = want.climate_valid ? temp_raw : '0;
            want.humidity_percent   = want.climate_valid ? humidity : '0;
            want.battery_percent    = want.battery_valid ? battery : '0;
            expected_reports.push_back(want);
            start_packet();
        endfunction

        function void check_result(input t_result got);
            t_result want;
            reports_seen++;
            if (expected_reports.size() == 0) begin
                errors++;
                if (errors <= ReportMax)
                    $display("ERROR: report with no packet waiting: acc=%0b", got.accepted);
                return;
            end
            want = expected_reports.pop_front();
            accepted_seen += want.accepted;
            climate_seen  += want.climate_valid;
            battery_seen  += want.battery_valid;
            if (got.accepted !== want.accepted
                || got.climate_valid !== want.climate_valid
                || got.temperature_tenths !== want.temperature_tenths
                || got.humidity_percent !== want.humidity_percent
                || got.battery_valid !== want.battery_valid
                || got.battery_percent !== want.battery_percent) begin
                errors++;
                if (errors <= ReportMax) begin
                    $display("ERROR: report %0d expected acc=%0b clim=%0b t=%0d h=%0d bat=%0b b=%0d",
                             reports_seen, want.accepted, want.climate_valid,
                             $signed(want.temperature_tenths), want.humidity_percent,
                             want.battery_valid, want.battery_percent);
                    $display("       got      acc=%0b clim=%0b t=%0d h=%0d bat=%0b b=%0d",
                             got.accepted, got.climate_valid,
                             $signed(got.temperature_tenths), got.humidity_percent,
                             got.battery_valid, got.battery_percent);
                end
            end
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_idx;
    logic [15:0]         i_cfg_wdata;
    logic                push;
    logic                full;
    logic [7:0]          i_data_byte;
    logic                i_last_byte;
    logic                empty;
    logic                pop;
    logic                o_accepted;
    logic                o_climate_valid;
    logic signed [15:0]  o_temperature_tenths;
    logic [7:0]          o_humidity_percent;
    logic                o_battery_valid;
    logic [7:0]          o_battery_percent;

    advert_scoreboard sb;
    logic [7:0]       pkt [$];
    bit               tx_idle_on;
    bit               rx_idle_on;
    logic             rx_hold_req;
    int               stall_cycles;
    int               packets_sent;

    sensor_advert_tlv_parser_top i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_wdata          (i_cfg_wdata),
        .push                 (push),
        .full                 (full),
        .i_data_byte          (i_data_byte),
        .i_last_byte          (i_last_byte),
        .empty                (empty),
        .pop                  (pop),
        .o_accepted           (o_accepted),
        .o_climate_valid      (o_climate_valid),
        .o_temperature_tenths (o_temperature_tenths),
        .o_humidity_percent   (o_humidity_percent),
        .o_battery_valid      (o_battery_valid),
        .o_battery_percent    (o_battery_percent)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Observe both handshakes at each edge and count cycles without progress
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty)
                sb.check_result('{o_accepted, o_climate_valid, o_temperature_tenths,
                                  o_humidity_percent, o_battery_valid, o_battery_percent});
            if (push && !full)
                sb.note_byte(i_data_byte, i_last_byte);
            if ((pop && !empty) || (push && !full))
                stall_cycles = 0;
            else
                stall_cycles = stall_cycles + 1;
        end
    end

    // Stop a hung run
    initial begin
        stall_cycles = 0;
        while (stall_cycles < WatchdogLimit)
            @(posedge i_clk);
        $display("ERROR: no handshake for %0d cycles", WatchdogLimit);
        $display("Mismatches found");
        $finish;
    end

    // Drain reports: random short stalls, one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        pop <= 1'b0;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else if (rx_hold_req) begin
                rx_hold_req <= 1'b0;
                stall_left = HoldOffCycles;
                pop <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 7);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Offer one item and hold it until the block takes it; push stays high
    task automatic push_byte(input logic [7:0] b, input logic lst);
        push        <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= lst;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
    endtask

    task automatic send_packet();
        foreach (pkt[i]) begin
            if (tx_idle_on && $urandom_range(0, 9) == 0) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            push_byte(pkt[i], i == pkt.size() - 1);
        end
        packets_sent++;
    endtask

    // Stop sending, wait for every report, then let the pipeline empty
    task automatic settle();
        push <= 1'b0;
        // Let the monitor note the last accepted item before counting reports
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Append one record with random values; return its size in bytes
    function automatic int add_record();
        int         r;
        int         len;
        logic [7:0] typ;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            typ = sb.climate_code;
            len = $urandom_range(ClimateLenMin, 6);
        end else if (r < 40) begin
            typ = sb.climate_code;
            len = $urandom_range(0, ClimateLenMin - 1);
        end else if (r < 65) begin
            typ = sb.battery_code;
            len = $urandom_range(BatteryLenMin, 3);
        end else if (r < 70) begin
            typ = sb.battery_code;
            len = 0;
        end else if (r < 97) begin
            typ = 8'($urandom_range(0, 255));
            len = $urandom_range(0, 5);
        end else begin
            typ = $urandom_range(0, 1) ? sb.climate_code : 8'($urandom_range(0, 255));
            len = $urandom_range(7, 255);
        end
        pkt.push_back(typ);
        pkt.push_back(8'(len));
        repeat (len) pkt.push_back(8'($urandom_range(0, 255)));
        return len + 2;
    endfunction

    // Mostly well-formed packets; some noise, runts, bad headers and cut records
    function automatic void build_packet();
        int kind;
        int tail;
        pkt.delete();
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 18) begin
            pkt.push_back(sb.company_id[7:0]);
            if ($urandom_range(0, 1))
                pkt.push_back(sb.company_id[15:8]);
        end else begin
            pkt.push_back(sb.company_id[7:0]);
            pkt.push_back(sb.company_id[15:8]);
            if (kind < 28)
                pkt[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
            repeat ($urandom_range(0, 4)) void'(add_record());
            if ($urandom_range(0, 3) == 0) begin
                tail = add_record();
                repeat ($urandom_range(1, tail - 1)) void'(pkt.pop_back());
            end
        end
    endfunction

    task automatic run_random(input int nbytes);
        int stop_at;
        stop_at = sb.bytes_seen + nbytes;
        while (sb.bytes_seen < stop_at) begin
            build_packet();
            send_packet();
        end
    endtask

    initial begin
        logic [7:0] code;
        sb           = new();
        packets_sent = 0;
        tx_idle_on   = 1'b1;
        rx_idle_on   = 1'b1;
        rx_hold_req  <= 1'b0;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= '0;
        i_cfg_wdata  <= '0;
        push         <= 1'b0;
        i_data_byte  <= '0;
        i_last_byte  <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Runt packet of a single byte
        pkt = '{CompanyIdDefault[7:0]};
        send_packet();
        // Wrong high header byte hides a complete battery record
        pkt = '{CompanyIdDefault[7:0], CompanyIdDefault[15:8] ^ 8'h03,
                BatteryCodeDefault, 8'd1, 8'h64};
        send_packet();
        // Coldest temperature, highest humidity byte, committed on the final byte
        pkt = '{CompanyIdDefault[7:0], CompanyIdDefault[15:8], ClimateCodeDefault,
                8'd4, 8'h00, 8'h80, 8'hFF, 8'h7F};
        send_packet();
        // Short climate record, empty battery record, good one, then a cut-off one
        pkt = '{CompanyIdDefault[7:0], CompanyIdDefault[15:8], ClimateCodeDefault,
                8'd3, 8'h11, 8'h22, 8'h33, BatteryCodeDefault, 8'd0, BatteryCodeDefault,
                8'd1, 8'h00, BatteryCodeDefault, 8'd2, 8'h64};
        send_packet();
        run_random(BytesPerSetting);

        // Low extremes, with a long hold-off on the report side
        settle();
        write_reg(CFG_COMPANY_ID, 16'h0000);
        write_reg(CFG_CLIMATE_TYPE, {8'($urandom_range(0, 255)), 8'h00});
        write_reg(CFG_BATTERY_TYPE, {8'($urandom_range(0, 255)), 8'hFF});
        write_reg(CfgIdxSpare, 16'($urandom));
        rx_hold_req <= 1'b1;
        run_random(BytesPerSetting);

        // High extremes
        settle();
        write_reg(CFG_COMPANY_ID, 16'hFFFF);
        write_reg(CFG_CLIMATE_TYPE, {8'($urandom_range(0, 255)), 8'hFF});
        write_reg(CFG_BATTERY_TYPE, {8'($urandom_range(0, 255)), 8'h00});
        run_random(BytesPerSetting);

        // One code for both record kinds
        settle();
        code = 8'($urandom_range(0, 255));
        write_reg(CFG_COMPANY_ID, 16'($urandom));
        write_reg(CFG_CLIMATE_TYPE, {8'($urandom_range(0, 255)), code});
        write_reg(CFG_BATTERY_TYPE, {8'($urandom_range(0, 255)), code});
        run_random(BytesPerSetting);

        // Random setting
        settle();
        write_reg(CFG_COMPANY_ID, 16'($urandom));
        write_reg(CFG_CLIMATE_TYPE, 16'($urandom));
        write_reg(CFG_BATTERY_TYPE, 16'($urandom));
        write_reg(CfgIdxSpare, 16'($urandom));
        run_random(BytesPerSetting);

        // Back to reset values, both sides at full rate
        settle();
        write_reg(CFG_COMPANY_ID, CompanyIdDefault);
        write_reg(CFG_CLIMATE_TYPE, {8'h00, ClimateCodeDefault});
        write_reg(CFG_BATTERY_TYPE, {8'h00, BatteryCodeDefault});
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_random(BytesPerSetting);

        settle();
        $display("Run covered %0d bytes in %0d packets under six register settings.",
                 sb.bytes_seen, packets_sent);
        $display("%0d reports checked: %0d accepted, %0d with climate, %0d with battery.",
                 sb.reports_seen, sb.accepted_seen, sb.climate_seen, sb.battery_seen);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
